/* rtl/arc_pkg.sv */
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants of the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int PROBE_COUNT   = 3;

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int PCNT_W = $clog2(PROBE_COUNT + 1);

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_RX      = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_PROBE   = 2'd3
    } action_t;

    localparam logic [2:0] KIND_IGNORED  = 3'd0;
    localparam logic [2:0] KIND_TX       = 3'd1;
    localparam logic [2:0] KIND_LEARNED  = 3'd2;
    localparam logic [2:0] KIND_LOOKUP   = 3'd3;
    localparam logic [2:0] KIND_CONFLICT = 3'd4;

    localparam logic [15:0] RX_OP_REQUEST = 16'd1;
    localparam logic [15:0] RX_OP_REPLY   = 16'd2;

    localparam logic [1:0] TX_OP_NONE    = 2'd0;
    localparam logic [1:0] TX_OP_REQUEST = 2'd1;
    localparam logic [1:0] TX_OP_REPLY   = 2'd2;

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_MATCH  = 2'd1,
        ST_COMMIT = 2'd2,
        ST_OUT    = 2'd3
    } state_t;

    typedef struct packed {
        logic load_in;
        logic match;
        logic commit;
        logic reload;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic is_probe;
    } status_t;

endpackage

/* rtl/arp_responder_with_cache.sv */
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// ARP responder: answers requests for the own address, learns announcements
// and replies into a 16-entry associative cache, serves lookups, sends requests and probes.
// ----------------------------------------------------------------------------
// Result path: the input transfer is captured, the cache is searched, then the result is committed.
// Sequencing: a probe gives PROBE_COUNT results and every other item gives one result;
// one item is in flight at a time, set by the search/commit sequencer.
// Reset: cache valid bits, victim pointer and own_ip clear at once; no sweep.
module arp_responder_with_cache
    import arc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [MAC_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       action,
    input  logic [15:0]      rx_opcode,
    input  logic [IP_W-1:0]  rx_sender_ip,
    input  logic [MAC_W-1:0] rx_sender_mac,
    input  logic [IP_W-1:0]  rx_target_ip,
    input  logic [IP_W-1:0]  query_ip,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       result_kind,
    output logic [1:0]       tx_opcode,
    output logic [MAC_W-1:0] tx_dest_mac,
    output logic [IP_W-1:0]  tx_sender_ip,
    output logic [IP_W-1:0]  tx_target_ip,
    output logic [IP_W-1:0]  entry_ip,
    output logic [MAC_W-1:0] entry_mac,
    output logic             hit,
    output logic             last
);

    cmd_t    cmd;
    status_t status;

    arc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    arc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .rx_opcode     (rx_opcode),
        .rx_sender_ip  (rx_sender_ip),
        .rx_sender_mac (rx_sender_mac),
        .rx_target_ip  (rx_target_ip),
        .query_ip      (query_ip),
        .result_kind   (result_kind),
        .tx_opcode     (tx_opcode),
        .tx_dest_mac   (tx_dest_mac),
        .tx_sender_ip  (tx_sender_ip),
        .tx_target_ip  (tx_target_ip),
        .entry_ip      (entry_ip),
        .entry_mac     (entry_mac),
        .hit           (hit),
        .last          (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("result after final transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> result_kind == KIND_TX)
        else $error("multi-result item is not a probe frame");

endmodule

/* rtl/arc_ctrl.sv */
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer: capture, cache search, commit, then one or more output transfers.
// ----------------------------------------------------------------------------
module arc_ctrl
    import arc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [PCNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                cmd.last   = !status.is_probe || (PROBE_COUNT == 1);
                cnt_next   = PCNT_W'(1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.is_probe && (cnt_reg < PCNT_W'(PROBE_COUNT)))
                    begin
                        cmd.reload = 1'b1;
                        cmd.last   = (cnt_reg == PCNT_W'(PROBE_COUNT - 1));
                        cnt_next   = cnt_reg + PCNT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/arc_datapath.sv */
// ----------------------------------------------------------------------------
// arc_datapath
// Input capture, own address register, associative cache and result register.
// ----------------------------------------------------------------------------
module arc_datapath
    import arc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [MAC_W-1:0] cfg_data,
    input  logic [1:0]       action,
    input  logic [15:0]      rx_opcode,
    input  logic [IP_W-1:0]  rx_sender_ip,
    input  logic [MAC_W-1:0] rx_sender_mac,
    input  logic [IP_W-1:0]  rx_target_ip,
    input  logic [IP_W-1:0]  query_ip,
    output logic [2:0]       result_kind,
    output logic [1:0]       tx_opcode,
    output logic [MAC_W-1:0] tx_dest_mac,
    output logic [IP_W-1:0]  tx_sender_ip,
    output logic [IP_W-1:0]  tx_target_ip,
    output logic [IP_W-1:0]  entry_ip,
    output logic [MAC_W-1:0] entry_mac,
    output logic             hit,
    output logic             last
);

    // own_mac is accepted on the write port but never appears in a result
    logic [IP_W-1:0]  own_ip_reg;

    action_t          act_reg;
    logic [15:0]      opc_reg;
    logic [IP_W-1:0]  sip_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  tip_reg;
    logic [IP_W-1:0]  qip_reg;

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]          key_reg [CACHE_ENTRIES];
    logic [MAC_W-1:0]         mac_reg [CACHE_ENTRIES];
    logic [IDX_W-1:0]         victim_reg, victim_next;

    logic [CACHE_ENTRIES-1:0] match_vec_reg, match_vec_next;
    logic [CACHE_ENTRIES-1:0] free_vec_reg;

    logic [2:0]       kind_reg, kind_next;
    logic [1:0]       txop_reg, txop_next;
    logic [MAC_W-1:0] dmac_reg, dmac_next;
    logic [IP_W-1:0]  tsip_reg, tsip_next;
    logic [IP_W-1:0]  ttip_reg, ttip_next;
    logic [IP_W-1:0]  eip_reg, eip_next;
    logic [MAC_W-1:0] emac_reg, emac_next;
    logic             hit_reg, hit_next;
    logic             last_reg;

    logic [IP_W-1:0]  search_ip;
    logic [IDX_W-1:0] match_idx, free_idx, slot;
    logic             any_match, any_free;
    logic             is_reply, do_learn, is_conflict, wr_cache;

    assign status.is_probe = (act_reg == ACT_PROBE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_wr_en && (cfg_index == REG_OWN_IP))
        begin
            own_ip_reg <= cfg_data[IP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg  <= action_t'(action);
            opc_reg  <= rx_opcode;
            sip_reg  <= rx_sender_ip;
            smac_reg <= rx_sender_mac;
            tip_reg  <= rx_target_ip;
            qip_reg  <= query_ip;
        end
    end

    assign search_ip = (act_reg == ACT_LOOKUP) ? qip_reg : sip_reg;

    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            match_vec_next[i] = valid_reg[i] && (key_reg[i] == search_ip);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vec_reg <= '0;
            free_vec_reg  <= '0;
        end
        else if (cmd.match)
        begin
            match_vec_reg <= match_vec_next;
            free_vec_reg  <= ~valid_reg;
        end
    end

    // lowest set index wins
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec_reg[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (free_vec_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |match_vec_reg;
    assign any_free  = |free_vec_reg;

    assign is_reply = (opc_reg == RX_OP_REQUEST) && (tip_reg == own_ip_reg);
    assign do_learn = ((opc_reg == RX_OP_REQUEST) && (tip_reg != own_ip_reg)
                       && (tip_reg == sip_reg))
                   || ((opc_reg == RX_OP_REPLY)
                       && ((tip_reg == '0) || (tip_reg == own_ip_reg)));
    assign is_conflict = (sip_reg == own_ip_reg);
    assign wr_cache = cmd.commit && (act_reg == ACT_RX) && !is_reply && do_learn
                   && !is_conflict;

    always_comb
    begin
        victim_next = victim_reg;
        if (any_match)
        begin
            slot = match_idx;
        end
        else if (any_free)
        begin
            slot = free_idx;
        end
        else
        begin
            slot = victim_reg;
            if (victim_reg == IDX_W'(CACHE_ENTRIES - 1))
            begin
                victim_next = '0;
            end
            else
            begin
                victim_next = victim_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            victim_reg <= '0;
        end
        else if (wr_cache)
        begin
            valid_reg[slot] <= 1'b1;
            victim_reg      <= victim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cache)
        begin
            key_reg[slot] <= sip_reg;
            mac_reg[slot] <= smac_reg;
        end
    end

    always_comb
    begin
        kind_next = KIND_IGNORED;
        txop_next = TX_OP_NONE;
        dmac_next = '0;
        tsip_next = '0;
        ttip_next = '0;
        eip_next  = '0;
        emac_next = '0;
        hit_next  = 1'b0;
        case (act_reg)
            ACT_RX:
            begin
                if (is_reply)
                begin
                    kind_next = KIND_TX;
                    txop_next = TX_OP_REPLY;
                    dmac_next = smac_reg;
                    tsip_next = own_ip_reg;
                    ttip_next = sip_reg;
                end
                else if (do_learn)
                begin
                    kind_next = is_conflict ? KIND_CONFLICT : KIND_LEARNED;
                    eip_next  = sip_reg;
                    emac_next = smac_reg;
                end
            end
            ACT_LOOKUP:
            begin
                kind_next = KIND_LOOKUP;
                eip_next  = qip_reg;
                hit_next  = any_match;
                emac_next = any_match ? mac_reg[match_idx] : '0;
            end
            ACT_REQUEST:
            begin
                kind_next = KIND_TX;
                txop_next = TX_OP_REQUEST;
                dmac_next = BCAST_MAC;
                tsip_next = own_ip_reg;
                ttip_next = qip_reg;
            end
            ACT_PROBE:
            begin
                kind_next = KIND_TX;
                txop_next = TX_OP_REQUEST;
                ttip_next = own_ip_reg;
            end
            default:
            begin
                kind_next = KIND_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            kind_reg <= kind_next;
            txop_reg <= txop_next;
            dmac_reg <= dmac_next;
            tsip_reg <= tsip_next;
            ttip_reg <= ttip_next;
            eip_reg  <= eip_next;
            emac_reg <= emac_next;
            hit_reg  <= hit_next;
        end
        if (cmd.commit || cmd.reload)
        begin
            last_reg <= cmd.last;
        end
    end

    assign result_kind  = kind_reg;
    assign tx_opcode    = txop_reg;
    assign tx_dest_mac  = dmac_reg;
    assign tx_sender_ip = tsip_reg;
    assign tx_target_ip = ttip_reg;
    assign entry_ip     = eip_reg;
    assign entry_mac    = emac_reg;
    assign hit          = hit_reg;
    assign last         = last_reg;

    // an address is held in at most one valid entry
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match_vec_reg))
        else $error("duplicate cache key");

    // the victim pointer moves only on a cache write with no match and no free entry
    assert property (@(posedge clk) disable iff (!rst_n)
        !wr_cache |=> $stable(victim_reg))
        else $error("victim pointer moved without eviction");

endmodule
